/* src/lccs_pkg.sv */
`timescale 1ns / 1ps

package lccs_pkg;

  // Digit entry geometry and fixed-point format of the factor.
  localparam int DigitCount   = 6;
  localparam int FractionBits = 8;

  // Field widths of the items.
  localparam int OpWidth      = 2;
  localparam int RawWidth     = 24;
  localparam int ModeWidth    = 2;
  localparam int GramsWidth   = 20;
  localparam int PosWidth     = 3;
  localparam int StatusWidth  = 3;
  localparam int FactorWidth  = 42;

  // Configuration port geometry.
  localparam int DataWidth    = 32;
  localparam int AddrWidth    = 3;
  localparam int IndexWidth   = AddrWidth - 2;
  localparam logic [GramsWidth-1:0] MaxGramsReset = GramsWidth'(50000);

  // Internal widths derived from the digit count and the factor format.
  localparam int SelWidth     = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam int WeightWidth  = 4 * DigitCount;
  localparam int DiffWidth    = RawWidth;
  localparam int ScaleWidth   = 10;
  localparam int ProdWidth    = DiffWidth + ScaleWidth;
  localparam int NumWidth     = ProdWidth + FractionBits;
  localparam int QuotWidth    = (NumWidth > FactorWidth) ? NumWidth : FactorWidth;
  localparam int DivCntWidth  = $clog2(QuotWidth + 1);

  // Grams to kilograms scaling.
  localparam logic [ScaleWidth-1:0] GramsPerKg = ScaleWidth'(1000);
  localparam logic [3:0] DigitMax = 4'd9;

  typedef enum logic [OpWidth-1:0] {
    OP_START   = 2'd0,
    OP_UP      = 2'd1,
    OP_SHIFT   = 2'd2,
    OP_CONFIRM = 2'd3
  } op_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_WAIT   = 2'd2
  } mode_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_NONE     = 3'd0,
    STATUS_REJECTED = 3'd1,
    STATUS_CAPTURED = 3'd2,
    STATUS_SUCCESS  = 3'd3,
    STATUS_INVALID  = 3'd4
  } status_e;

  typedef enum logic [IndexWidth-1:0] {
    REG_MAX_GRAMS = 1'd0
  } reg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef logic [DigitCount-1:0][3:0] digits_t;

  typedef struct packed {
    op_e                        operation;
    logic signed [RawWidth-1:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    mode_e                   mode;
    logic [GramsWidth-1:0]   entered_grams;
    logic [PosWidth-1:0]     digit_position;
    status_e                 status;
    logic [FactorWidth-1:0]  factor_q8;
  } out_item_t;

  // Request to and response from the serial divider.
  typedef struct packed {
    logic                   start;
    logic [QuotWidth-1:0]   numerator;
    logic [WeightWidth-1:0] denominator;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QuotWidth-1:0] quotient;
  } div_rsp_t;

  // Decimal digits to binary weight, most significant digit first.
  function automatic logic [WeightWidth-1:0] compose_weight(digits_t d);
    logic [WeightWidth-1:0] acc;
    acc = '0;
    for (int i = DigitCount - 1; i >= 0; i--) begin
      acc = WeightWidth'(acc * WeightWidth'(10)) + WeightWidth'(d[i]);
    end
    return acc;
  endfunction

  // Clamp the quotient to the width of the factor field.
  function automatic logic [FactorWidth-1:0] saturate_factor(logic [QuotWidth-1:0] q);
    logic [FactorWidth-1:0] res;
    if (|(q >> FactorWidth)) begin
      res = '1;
    end else begin
      res = q[FactorWidth-1:0];
    end
    return res;
  endfunction

endpackage

/* src/lccs_divider.sv */
`timescale 1ns / 1ps

module lccs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lccs_pkg::div_req_t req_i,
  output lccs_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [lccs_pkg::DivCntWidth-1:0]    cnt_q, cnt_d;
  logic [lccs_pkg::QuotWidth-1:0]      num_q, num_d;
  logic [lccs_pkg::WeightWidth-1:0]    rem_q, rem_d;
  logic [lccs_pkg::WeightWidth-1:0]    den_q, den_d;
  logic [lccs_pkg::WeightWidth:0]      rem_shift;
  logic [lccs_pkg::WeightWidth:0]      rem_sub;
  logic                                fits;

  // One restoring step: bring down the next numerator bit and try a subtract.
  assign rem_shift = {rem_q, num_q[lccs_pkg::QuotWidth-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign fits      = (rem_shift >= {1'b0, den_q});

  // The numerator register fills with quotient bits from the bottom.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lccs_pkg::DivCntWidth'(lccs_pkg::QuotWidth);
      num_d  = req_i.numerator;
      rem_d  = '0;
      den_d  = req_i.denominator;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[lccs_pkg::WeightWidth-1:0]
                   : rem_shift[lccs_pkg::WeightWidth-1:0];
      num_d = {num_q[lccs_pkg::QuotWidth-2:0], fits};
      cnt_d = cnt_q - lccs_pkg::DivCntWidth'(1);
      if (cnt_q == lccs_pkg::DivCntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

/* src/load_cell_calibration_sequencer.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   in_item_i  (operation, raw_reading)
// output    out_valid_o / out_ready_i out_item_o (mode, grams, position, status, factor)
// config    psel/penable/pwrite       paddr, pwdata, prdata (max_grams at 0x0)
//
// Start, up, shift and confirms without a divide pass from decode (ST_EXEC) to handoff (ST_DONE);
// an up in edit mode passes ST_CHECK between them, which checks the limit. The next item is
// taken once the sequencer is back in ST_IDLE. A calibrating confirm goes through decode,
// multiply, divider start, the bit-serial divider (one quotient bit per cycle, 42 bits),
// divider finish and handoff.
// One item is worked at a time; in_ready_o is high only while the sequencer is idle.
// The result sits in an output register, so a stalled output holds only the next finish.
// Reset is asynchronous and active low; no clearing pass is needed.

module load_cell_calibration_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lccs_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lccs_pkg::out_item_t                  out_item_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lccs_pkg::AddrWidth-1:0]       paddr,
  input  logic [lccs_pkg::DataWidth-1:0]       pwdata,
  output logic [lccs_pkg::DataWidth-1:0]       prdata,
  output logic                                 pready
);

  lccs_pkg::state_e                       state_q, state_d;
  lccs_pkg::op_e                          op_q, op_d;
  logic signed [lccs_pkg::RawWidth-1:0]   raw_q, raw_d;
  lccs_pkg::mode_e                        mode_q, mode_d;
  lccs_pkg::digits_t                      digits_q, digits_d;
  logic [lccs_pkg::SelWidth-1:0]          sel_q, sel_d;
  logic signed [lccs_pkg::RawWidth-1:0]   ref_q, ref_d;
  logic [lccs_pkg::FactorWidth-1:0]       factor_q, factor_d;
  lccs_pkg::status_e                      status_q, status_d;
  logic [lccs_pkg::DiffWidth-1:0]         diff_q, diff_d;
  logic [lccs_pkg::ProdWidth-1:0]         prod_q, prod_d;
  logic [lccs_pkg::GramsWidth-1:0]        max_grams_q;
  logic                                   out_valid_q, out_valid_d;
  lccs_pkg::out_item_t                    out_q, out_d;

  logic [lccs_pkg::WeightWidth-1:0]       grams;
  logic                                   grams_bad;
  logic signed [lccs_pkg::RawWidth:0]     diff_full;
  logic                                   out_free;
  logic                                   cfg_write;
  logic [lccs_pkg::IndexWidth-1:0]        cfg_index;
  lccs_pkg::div_req_t                     div_req;
  lccs_pkg::div_rsp_t                     div_rsp;

  // Configuration register; every access completes at once.
  assign pready    = 1'b1;
  assign cfg_index = paddr[lccs_pkg::AddrWidth-1:2];
  assign cfg_write = psel && penable && pwrite
                     && (cfg_index == lccs_pkg::REG_MAX_GRAMS);
  assign prdata    = (cfg_index == lccs_pkg::REG_MAX_GRAMS)
                     ? lccs_pkg::DataWidth'(max_grams_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_grams_q <= lccs_pkg::MaxGramsReset;
    end else if (cfg_write) begin
      max_grams_q <= pwdata[lccs_pkg::GramsWidth-1:0];
    end
  end

  // Weight from the digits and the loaded-minus-empty difference.
  assign grams     = lccs_pkg::compose_weight(digits_q);
  assign grams_bad = (grams == '0)
                     || (grams > lccs_pkg::WeightWidth'(max_grams_q));
  assign diff_full = {raw_q[lccs_pkg::RawWidth-1], raw_q}
                     - {ref_q[lccs_pkg::RawWidth-1], ref_q};
  assign out_free  = !out_valid_q || out_ready_i;

  // Serial divider for the factor.
  assign div_req.start       = (state_q == lccs_pkg::ST_DSTART);
  assign div_req.numerator   = lccs_pkg::QuotWidth'(prod_q) << lccs_pkg::FractionBits;
  assign div_req.denominator = grams;

  lccs_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_ready_o = (state_q == lccs_pkg::ST_IDLE);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    raw_d       = raw_q;
    mode_d      = mode_q;
    digits_d    = digits_q;
    sel_d       = sel_q;
    ref_d       = ref_q;
    factor_d    = factor_q;
    status_d    = status_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      lccs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.operation;
          raw_d    = in_item_i.raw_reading;
          status_d = lccs_pkg::STATUS_NONE;
          state_d  = lccs_pkg::ST_EXEC;
        end
      end

      lccs_pkg::ST_EXEC: begin
        state_d = lccs_pkg::ST_DONE;
        unique case (op_q)
          lccs_pkg::OP_START: begin
            digits_d = '0;
            sel_d    = '0;
            mode_d   = lccs_pkg::MODE_EDIT;
          end
          lccs_pkg::OP_UP: begin
            if (mode_q == lccs_pkg::MODE_EDIT) begin
              digits_d[sel_q] = (digits_q[sel_q] >= lccs_pkg::DigitMax)
                                ? 4'd0 : digits_q[sel_q] + 4'd1;
              state_d = lccs_pkg::ST_CHECK;
            end
          end
          lccs_pkg::OP_SHIFT: begin
            if (mode_q == lccs_pkg::MODE_EDIT) begin
              sel_d = (sel_q == lccs_pkg::SelWidth'(lccs_pkg::DigitCount - 1))
                      ? '0 : sel_q + lccs_pkg::SelWidth'(1);
            end
          end
          lccs_pkg::OP_CONFIRM: begin
            if (mode_q == lccs_pkg::MODE_EDIT) begin
              if (grams_bad) begin
                status_d = lccs_pkg::STATUS_REJECTED;
              end else begin
                ref_d    = raw_q;
                mode_d   = lccs_pkg::MODE_WAIT;
                status_d = lccs_pkg::STATUS_CAPTURED;
              end
            end else if (mode_q == lccs_pkg::MODE_WAIT) begin
              mode_d = lccs_pkg::MODE_NORMAL;
              if (!diff_full[lccs_pkg::RawWidth] && (diff_full != '0) && (grams != '0)) begin
                diff_d  = diff_full[lccs_pkg::DiffWidth-1:0];
                state_d = lccs_pkg::ST_MUL;
              end else begin
                status_d = lccs_pkg::STATUS_INVALID;
              end
            end
          end
          default: ;
        endcase
      end

      // Weight above the limit falls back to zero.
      lccs_pkg::ST_CHECK: begin
        if (grams > lccs_pkg::WeightWidth'(max_grams_q)) begin
          digits_d = '0;
        end
        state_d = lccs_pkg::ST_DONE;
      end

      lccs_pkg::ST_MUL: begin
        prod_d  = lccs_pkg::ProdWidth'(diff_q) * lccs_pkg::ProdWidth'(lccs_pkg::GramsPerKg);
        state_d = lccs_pkg::ST_DSTART;
      end

      lccs_pkg::ST_DSTART: begin
        state_d = lccs_pkg::ST_DIV;
      end

      lccs_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          factor_d = lccs_pkg::saturate_factor(div_rsp.quotient);
          status_d = lccs_pkg::STATUS_SUCCESS;
          state_d  = lccs_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it has room.
      lccs_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.mode           = mode_q;
          out_d.entered_grams  = grams[lccs_pkg::GramsWidth-1:0];
          out_d.digit_position = lccs_pkg::PosWidth'(sel_q);
          out_d.status         = status_q;
          out_d.factor_q8      = factor_q;
          out_valid_d          = 1'b1;
          state_d              = lccs_pkg::ST_IDLE;
        end
      end

      default: state_d = lccs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lccs_pkg::ST_IDLE;
      mode_q      <= lccs_pkg::MODE_NORMAL;
      digits_q    <= '0;
      sel_q       <= '0;
      ref_q       <= '0;
      factor_q    <= '0;
      status_q    <= lccs_pkg::STATUS_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      digits_q    <= digits_d;
      sel_q       <= sel_d;
      ref_q       <= ref_d;
      factor_q    <= factor_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload and arithmetic operands.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    raw_q  <= raw_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An accepted item closes the input until its result is produced.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == lccs_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  // The digit selector never leaves the digit range.
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q < lccs_pkg::SelWidth'(lccs_pkg::DigitCount))
    else $error("digit selector out of range");

endmodule

/* verif/tb_load_cell_calibration_sequencer.sv */
`timescale 1ns / 1ps

module tb_load_cell_calibration_sequencer;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 64;
  localparam int PhaseItems = 105;
  localparam logic [lccs_pkg::AddrWidth-1:0] MaxGramsAddr =
    lccs_pkg::AddrWidth'(lccs_pkg::REG_MAX_GRAMS) << 2;
  localparam longint unsigned FactorMax = (64'd1 << lccs_pkg::FactorWidth) - 1;

  // Clock, reset and the ports of the block.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lccs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lccs_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lccs_pkg::AddrWidth-1:0] paddr = '0;
  logic [lccs_pkg::DataWidth-1:0] pwdata = '0;
  logic [lccs_pkg::DataWidth-1:0] prdata;
  logic pready;

  // Shadow copy of the calibration state and of the weight limit.
  lccs_pkg::mode_e cal_mode = lccs_pkg::MODE_NORMAL;
  logic [3:0] cal_digits [lccs_pkg::DigitCount] = '{default: 4'd0};
  logic [lccs_pkg::SelWidth-1:0] cal_sel = '0;
  longint cal_reference = 0;
  logic [lccs_pkg::FactorWidth-1:0] cal_factor = '0;
  logic [lccs_pkg::GramsWidth-1:0] grams_limit = lccs_pkg::MaxGramsReset;

  // Readouts still owed by the block, oldest first.
  lccs_pkg::out_item_t pending_readouts [$];
  lccs_pkg::out_item_t want;

  // Run bookkeeping.
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int calibrations = 0;
  int refusals = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit in_gaps_on = 1'b0;
  bit out_gaps_on = 1'b0;

  load_cell_calibration_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Weight in grams from the decimal digits, most significant digit first.
  function automatic longint unsigned entered_weight();
    longint unsigned acc;
    acc = 0;
    for (int i = lccs_pkg::DigitCount - 1; i >= 0; i--) begin
      acc = acc * 10 + cal_digits[i];
    end
    return acc;
  endfunction

  // Advances the shadow state by one button event and returns the readout it causes.
  function automatic lccs_pkg::out_item_t advance_calibration(lccs_pkg::in_item_t it);
    lccs_pkg::out_item_t res;
    lccs_pkg::status_e st;
    longint raw;
    longint diff;
    longint unsigned grams;
    longint unsigned quot;
    st = lccs_pkg::STATUS_NONE;
    raw = {{(64 - lccs_pkg::RawWidth){it.raw_reading[lccs_pkg::RawWidth-1]}}, it.raw_reading};
    case (it.operation)
      lccs_pkg::OP_START: begin
        cal_digits = '{default: 4'd0};
        cal_sel = '0;
        cal_mode = lccs_pkg::MODE_EDIT;
      end
      lccs_pkg::OP_UP: begin
        if (cal_mode == lccs_pkg::MODE_EDIT) begin
          cal_digits[cal_sel] = (cal_digits[cal_sel] >= 4'd9) ? 4'd0
                                : cal_digits[cal_sel] + 4'd1;
          // An entry above the limit falls back to zero as a whole.
          if (entered_weight() > grams_limit) begin
            cal_digits = '{default: 4'd0};
          end
        end
      end
      lccs_pkg::OP_SHIFT: begin
        if (cal_mode == lccs_pkg::MODE_EDIT) begin
          cal_sel = (cal_sel == lccs_pkg::SelWidth'(lccs_pkg::DigitCount - 1)) ? '0
                    : cal_sel + lccs_pkg::SelWidth'(1);
        end
      end
      lccs_pkg::OP_CONFIRM: begin
        grams = entered_weight();
        if (cal_mode == lccs_pkg::MODE_EDIT) begin
          if (grams == 0 || grams > grams_limit) begin
            st = lccs_pkg::STATUS_REJECTED;
          end else begin
            cal_reference = raw;
            cal_mode = lccs_pkg::MODE_WAIT;
            st = lccs_pkg::STATUS_CAPTURED;
          end
        end else if (cal_mode == lccs_pkg::MODE_WAIT) begin
          diff = raw - cal_reference;
          if (diff > 0 && grams != 0) begin
            quot = ((unsigned'(diff) * 1000) << lccs_pkg::FractionBits) / grams;
            cal_factor = (quot > FactorMax) ? lccs_pkg::FactorWidth'(FactorMax)
                         : quot[lccs_pkg::FactorWidth-1:0];
            st = lccs_pkg::STATUS_SUCCESS;
          end else begin
            st = lccs_pkg::STATUS_INVALID;
          end
          cal_mode = lccs_pkg::MODE_NORMAL;
        end
      end
    endcase
    res.mode = cal_mode;
    res.entered_grams = lccs_pkg::GramsWidth'(entered_weight());
    res.digit_position = lccs_pkg::PosWidth'(cal_sel);
    res.status = st;
    res.factor_q8 = cal_factor;
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  // Presents one item, waits for it to be taken and records the readout it owes.
  task automatic send_event(input lccs_pkg::op_e op,
                            input logic [lccs_pkg::RawWidth-1:0] raw);
    lccs_pkg::in_item_t it;
    lccs_pkg::out_item_t res;
    it.operation = op;
    it.raw_reading = raw;
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = advance_calibration(it);
    pending_readouts.push_back(res);
    items_sent++;
    if (res.status == lccs_pkg::STATUS_SUCCESS) begin
      calibrations++;
    end else if (res.status == lccs_pkg::STATUS_REJECTED
                 || res.status == lccs_pkg::STATUS_INVALID) begin
      refusals++;
    end
  endtask

  // Random reading for events that carry no meaningful one.
  function automatic logic [lccs_pkg::RawWidth-1:0] any_raw();
    return lccs_pkg::RawWidth'($urandom());
  endfunction

  // Drops valid and waits until every owed readout has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  // Writes the weight limit, then reads it back in the access right after.
  task automatic set_grams_limit(input logic [lccs_pkg::DataWidth-1:0] data);
    logic [lccs_pkg::DataWidth-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MaxGramsAddr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    grams_limit = data[lccs_pkg::GramsWidth-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    compare_field("max_grams readback", 64'(grams_limit), 64'(readback));
  endtask

  // Up, shift and confirm outside edit mode leave everything as it is.
  task automatic test_idle_events();
    send_event(lccs_pkg::OP_UP, any_raw());
    send_event(lccs_pkg::OP_SHIFT, any_raw());
    send_event(lccs_pkg::OP_CONFIRM, any_raw());
  endtask

  // Zero weight is refused, then the selector goes once around all digits.
  task automatic test_digit_entry();
    send_event(lccs_pkg::OP_START, any_raw());
    send_event(lccs_pkg::OP_CONFIRM, any_raw());
    send_event(lccs_pkg::OP_UP, any_raw());
    repeat (lccs_pkg::DigitCount) send_event(lccs_pkg::OP_SHIFT, any_raw());
  endtask

  // Reference at the most negative reading, load at the most positive, one gram.
  task automatic test_calibration_extremes();
    send_event(lccs_pkg::OP_CONFIRM, 24'h800000);
    send_event(lccs_pkg::OP_CONFIRM, 24'h7FFFFF);
  endtask

  // A zero and a negative difference are both errors and keep the old factor.
  task automatic test_bad_differences();
    send_event(lccs_pkg::OP_START, any_raw());
    send_event(lccs_pkg::OP_UP, any_raw());
    send_event(lccs_pkg::OP_CONFIRM, 24'h000000);
    send_event(lccs_pkg::OP_CONFIRM, 24'h000000);
    send_event(lccs_pkg::OP_START, any_raw());
    send_event(lccs_pkg::OP_UP, any_raw());
    send_event(lccs_pkg::OP_CONFIRM, 24'h000005);
    send_event(lccs_pkg::OP_CONFIRM, 24'hFFFFFD);
  endtask

  // Lowering the limit under a held entry, a zero limit, and the widest value.
  task automatic test_limit_register();
    send_event(lccs_pkg::OP_START, any_raw());
    send_event(lccs_pkg::OP_UP, any_raw());
    wait_for_results();
    // Upper bits are dropped, so this write leaves a limit of zero.
    set_grams_limit(32'hFFF0_0000);
    send_event(lccs_pkg::OP_CONFIRM, any_raw());
    send_event(lccs_pkg::OP_UP, any_raw());
    wait_for_results();
    set_grams_limit(32'hFFFF_FFFF);
  endtask

  // Mostly complete calibrations with random digits and readings, some stray events.
  task automatic run_random_events(input int budget);
    int first_item;
    int top;
    logic [lccs_pkg::RawWidth-1:0] empty_raw;
    logic [lccs_pkg::RawWidth-1:0] loaded_raw;
    first_item = items_sent;
    while (items_sent - first_item < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        send_event(lccs_pkg::OP_START, any_raw());
        top = $urandom_range(0, lccs_pkg::DigitCount - 1);
        for (int d = 0; d <= top; d++) begin
          repeat ($urandom_range(0, 9)) send_event(lccs_pkg::OP_UP, any_raw());
          if (d < top) begin
            send_event(lccs_pkg::OP_SHIFT, any_raw());
          end
        end
        empty_raw = any_raw();
        case ($urandom_range(0, 4))
          0: loaded_raw = empty_raw + lccs_pkg::RawWidth'($urandom_range(1, 100));
          1: loaded_raw = empty_raw + lccs_pkg::RawWidth'($urandom_range(1, 1 << 22));
          2: loaded_raw = empty_raw;
          3: loaded_raw = empty_raw - lccs_pkg::RawWidth'($urandom_range(1, 1000));
          default: loaded_raw = any_raw();
        endcase
        send_event(lccs_pkg::OP_CONFIRM, empty_raw);
        send_event(lccs_pkg::OP_CONFIRM, loaded_raw);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_event(lccs_pkg::op_e'($urandom_range(0, 3)), any_raw());
        end
      end
    end
  endtask

  // One random phase per weight limit; the last phase runs without idling.
  task automatic test_random_phases();
    logic [lccs_pkg::DataWidth-1:0] limits [6];
    limits = '{32'd50000, 32'd1, 32'd0, 32'd999999, 32'd1048575,
               lccs_pkg::DataWidth'($urandom_range(1, 999999))};
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      set_grams_limit(limits[p]);
      in_gaps_on = (p < 5);
      out_gaps_on = (p < 5);
      run_random_events(PhaseItems);
    end
  endtask

  // Output back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each readout taken is checked against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        mismatches++;
        $display("%0t: readout with no item outstanding, expected none, actual %h",
                 $time, out_item);
      end else begin
        want = pending_readouts.pop_front();
        compare_field("mode", 64'(want.mode), 64'(out_item.mode));
        compare_field("entered_grams", 64'(want.entered_grams), 64'(out_item.entered_grams));
        compare_field("digit_position", 64'(want.digit_position),
                      64'(out_item.digit_position));
        compare_field("status", 64'(want.status), 64'(out_item.status));
        compare_field("factor_q8", 64'(want.factor_q8), 64'(out_item.factor_q8));
        results_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles", $time, CycleLimit);
    $display("status: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    test_idle_events();
    test_digit_entry();
    test_calibration_extremes();
    test_bad_differences();
    test_limit_register();
    test_random_phases();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Checked %0d readouts for %0d button events across six weight limits.",
             results_checked, items_sent);
    $display("%0d calibrations completed, %0d confirms refused or failed.",
             calibrations, refusals);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lccs_pkg.sv
src/lccs_divider.sv
src/load_cell_calibration_sequencer.sv
verif/tb_load_cell_calibration_sequencer.sv
